>>> rtl/rths_pkg.sv
package rths_pkg;

    localparam int HUE_FRAC_BITS_DEF  = 6;
    localparam int UNIT_FRAC_BITS_DEF = 16;

    localparam int RGB_W      = 8;
    localparam int HUE_OUT_W  = 15;
    localparam int UNIT_OUT_W = 17;
    localparam int S_TDATA_W  = 3 * RGB_W;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - HUE_OUT_W - 2 * UNIT_OUT_W;

    // divider remainder, holds any divisor up to the luminance constant
    localparam int REM_W   = 9;
    localparam int LUM_DIV = 510;

    localparam int NUM_LANES = 3;
    localparam int LANE_HUE  = 0;
    localparam int LANE_SAT  = 1;
    localparam int LANE_LUM  = 2;

    typedef enum logic [1:0] {
        HB_ZERO = 2'd0,
        HB_TWO  = 2'd1,
        HB_FOUR = 2'd2,
        HB_SIX  = 2'd3
    } t_hue_base;

    typedef struct packed {
        logic      grey;
        logic      neg;
        t_hue_base base;
    } t_ctl;

    function automatic int div_steps(input int hue_frac, input int unit_frac);
        int hq;
        hq = $clog2((60 << hue_frac) + 1);
        return (unit_frac + 1 > hq) ? unit_frac + 1 : hq;
    endfunction

endpackage

>>> rtl/rths_prep.sv
module rths_prep
    import rths_pkg::*;
#(
    parameter int HUE_FRAC_BITS  = HUE_FRAC_BITS_DEF,
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF,
    parameter int STEPS          = div_steps(HUE_FRAC_BITS_DEF, UNIT_FRAC_BITS_DEF)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ld,
    input  logic                               i_vld,
    input  logic [RGB_W-1:0]                   i_red,
    input  logic [RGB_W-1:0]                   i_green,
    input  logic [RGB_W-1:0]                   i_blue,
    output logic                               o_vld,
    output t_ctl                               o_ctl,
    output logic [NUM_LANES-1:0][REM_W-1:0]    o_rem,
    output logic [NUM_LANES-1:0][STEPS-1:0]    o_w,
    output logic [NUM_LANES-1:0][REM_W-1:0]    o_div
);

    localparam int XW = STEPS + REM_W;

    logic [RGB_W-1:0]   mx, mn, delta, den, mag;
    logic [RGB_W:0]     sum, d;
    logic [RGB_W+5:0]   m60;
    logic [XW-1:0]      hue_x, sat_x, lum_x;
    t_ctl               n_ctl;
    logic [NUM_LANES-1:0][REM_W-1:0] n_rem, n_div;
    logic [NUM_LANES-1:0][STEPS-1:0] n_w;

    logic                            r_vld;
    t_ctl                            r_ctl;
    logic [NUM_LANES-1:0][REM_W-1:0] r_rem, r_div;
    logic [NUM_LANES-1:0][STEPS-1:0] r_w;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        sum   = {1'b0, mx} + {1'b0, mn};
        delta = mx - mn;
        den   = (sum <= (RGB_W+1)'(255)) ? sum[RGB_W-1:0]
                                         : RGB_W'((RGB_W+1)'(LUM_DIV) - sum);

        // first channel equal to the max picks the sector
        priority if (mx == i_red) begin
            d = {1'b0, i_green} - {1'b0, i_blue};
        end else if (mx == i_green) begin
            d = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            d = {1'b0, i_red} - {1'b0, i_green};
        end

        n_ctl.grey = (delta == '0);
        n_ctl.neg  = d[RGB_W];
        priority if (mx == i_red) begin
            n_ctl.base = d[RGB_W] ? HB_SIX : HB_ZERO;
        end else if (mx == i_green) begin
            n_ctl.base = HB_TWO;
        end else begin
            n_ctl.base = HB_FOUR;
        end

        mag = d[RGB_W] ? RGB_W'(-d) : d[RGB_W-1:0];
        m60 = ({6'b0, mag} << 6) - ({6'b0, mag} << 2);

        // negative hue rounds the magnitude up: add delta-1 before the floor
        hue_x = (XW'(m60) << HUE_FRAC_BITS)
              + (d[RGB_W] ? (XW'(delta) - XW'(1)) : '0);
        sat_x = XW'(delta) << UNIT_FRAC_BITS;
        lum_x = XW'(sum) << UNIT_FRAC_BITS;

        n_rem[LANE_HUE] = hue_x[XW-1:STEPS];
        n_rem[LANE_SAT] = sat_x[XW-1:STEPS];
        n_rem[LANE_LUM] = lum_x[XW-1:STEPS];
        n_w[LANE_HUE]   = hue_x[STEPS-1:0];
        n_w[LANE_SAT]   = sat_x[STEPS-1:0];
        n_w[LANE_LUM]   = lum_x[STEPS-1:0];
        n_div[LANE_HUE] = {1'b0, delta};
        n_div[LANE_SAT] = {1'b0, den};
        n_div[LANE_LUM] = REM_W'(LUM_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_ctl <= n_ctl;
            r_rem <= n_rem;
            r_w   <= n_w;
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_w   = r_w;
    assign o_div = r_div;

endmodule

>>> rtl/rths_div_cell.sv
module rths_div_cell
    import rths_pkg::*;
#(
    parameter int STEPS = div_steps(HUE_FRAC_BITS_DEF, UNIT_FRAC_BITS_DEF)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  t_ctl                               i_ctl,
    input  logic [NUM_LANES-1:0][REM_W-1:0]    i_rem,
    input  logic [NUM_LANES-1:0][STEPS-1:0]    i_w,
    input  logic [NUM_LANES-1:0][REM_W-1:0]    i_div,
    output logic                               o_vld,
    output t_ctl                               o_ctl,
    output logic [NUM_LANES-1:0][REM_W-1:0]    o_rem,
    output logic [NUM_LANES-1:0][STEPS-1:0]    o_w,
    output logic [NUM_LANES-1:0][REM_W-1:0]    o_div
);

    logic [NUM_LANES-1:0][REM_W:0]   trial, diff;
    logic [NUM_LANES-1:0]            ge;
    logic [NUM_LANES-1:0][REM_W-1:0] n_rem;
    logic [NUM_LANES-1:0][STEPS-1:0] n_w;

    logic                            r_vld;
    t_ctl                            r_ctl;
    logic [NUM_LANES-1:0][REM_W-1:0] r_rem, r_div;
    logic [NUM_LANES-1:0][STEPS-1:0] r_w;

    // one restoring step per lane: quotient bit shifts in at the bottom of w
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            trial[k] = {i_rem[k], i_w[k][STEPS-1]};
            diff[k]  = trial[k] - {1'b0, i_div[k]};
            ge[k]    = (trial[k] >= {1'b0, i_div[k]});
            n_rem[k] = ge[k] ? diff[k][REM_W-1:0] : trial[k][REM_W-1:0];
            n_w[k]   = {i_w[k][STEPS-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_rem <= n_rem;
            r_w   <= n_w;
            r_div <= i_div;
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_w   = r_w;
    assign o_div = r_div;

endmodule

>>> rtl/rths_post.sv
module rths_post
    import rths_pkg::*;
#(
    parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
    parameter int STEPS         = div_steps(HUE_FRAC_BITS_DEF, UNIT_FRAC_BITS_DEF)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    input  t_ctl                               i_ctl,
    input  logic [NUM_LANES-1:0][STEPS-1:0]    i_w,
    input  logic                               i_ready,
    output logic                               o_adv,
    output logic                               o_vld,
    output logic [HUE_OUT_W-1:0]               o_hue,
    output logic [UNIT_OUT_W-1:0]              o_sat,
    output logic [UNIT_OUT_W-1:0]              o_lum
);

    localparam int HUE_SCALE = 60 << HUE_FRAC_BITS;
    localparam int HW        = $clog2(6 * HUE_SCALE + 1);

    logic [HW-1:0]         hq, base_val, hue;
    logic [HUE_OUT_W-1:0]  n_hue;
    logic [UNIT_OUT_W-1:0] n_sat, n_lum;

    logic                  r_vld;
    logic [HUE_OUT_W-1:0]  r_hue;
    logic [UNIT_OUT_W-1:0] r_sat, r_lum;

    always_comb begin
        hq = HW'(i_w[LANE_HUE]);
        unique case (i_ctl.base)
            HB_ZERO: base_val = '0;
            HB_TWO:  base_val = HW'(2 * HUE_SCALE);
            HB_FOUR: base_val = HW'(4 * HUE_SCALE);
            HB_SIX:  base_val = HW'(6 * HUE_SCALE);
        endcase
        hue   = base_val + (i_ctl.neg ? (HW'(0) - hq) : hq);
        n_hue = i_ctl.grey ? '0 : HUE_OUT_W'(hue);
        n_sat = i_ctl.grey ? '0 : UNIT_OUT_W'(i_w[LANE_SAT]);
        n_lum = UNIT_OUT_W'(i_w[LANE_LUM]);
    end

    assign o_adv = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_lum <= n_lum;
        end
    end

    assign o_vld = r_vld;
    assign o_hue = r_hue;
    assign o_sat = r_sat;
    assign o_lum = r_lum;

endmodule

>>> rtl/rgb_to_hsl_convert.sv
// an item passes the prep register, the divider cells and the output register in order,
// STEPS = max(UNIT_FRAC_BITS + 1, bits of the hue quotient), one divider cell each
// throughput: one item per cycle while not stalled, the cell row runs all three divisions in parallel
// the whole row advances together and stalls only while the output item is held
// reset (synchronous, active low) clears the valid flags, data registers keep content
module rgb_to_hsl_convert
    import rths_pkg::*;
#(
    parameter int HUE_FRAC_BITS  = HUE_FRAC_BITS_DEF,
    parameter int UNIT_FRAC_BITS = UNIT_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // red_in, green_in, blue_in
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // hue_out, saturation_out, luminance_out, zero pad
);

    localparam int STEPS = div_steps(HUE_FRAC_BITS, UNIT_FRAC_BITS);

    logic                            w_en;
    logic                            w_ld;
    logic                            c_vld [0:STEPS];
    t_ctl                            c_ctl [0:STEPS];
    logic [NUM_LANES-1:0][REM_W-1:0] c_rem [0:STEPS];
    logic [NUM_LANES-1:0][STEPS-1:0] c_w   [0:STEPS];
    logic [NUM_LANES-1:0][REM_W-1:0] c_div [0:STEPS];
    logic [HUE_OUT_W-1:0]            w_hue;
    logic [UNIT_OUT_W-1:0]           w_sat, w_lum;

    // head register also fills while the row is stalled, if it is empty
    assign w_ld       = w_en || !c_vld[0];
    assign o_s_tready = w_ld;

    rths_prep #(
        .HUE_FRAC_BITS  (HUE_FRAC_BITS),
        .UNIT_FRAC_BITS (UNIT_FRAC_BITS),
        .STEPS          (STEPS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ld),
        .i_vld   (i_s_tvalid),
        .i_red   (i_s_tdata[RGB_W-1:0]),
        .i_green (i_s_tdata[2*RGB_W-1:RGB_W]),
        .i_blue  (i_s_tdata[3*RGB_W-1:2*RGB_W]),
        .o_vld   (c_vld[0]),
        .o_ctl   (c_ctl[0]),
        .o_rem   (c_rem[0]),
        .o_w     (c_w[0]),
        .o_div   (c_div[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        rths_div_cell #(
            .STEPS (STEPS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (c_vld[k]),
            .i_ctl   (c_ctl[k]),
            .i_rem   (c_rem[k]),
            .i_w     (c_w[k]),
            .i_div   (c_div[k]),
            .o_vld   (c_vld[k+1]),
            .o_ctl   (c_ctl[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_w     (c_w[k+1]),
            .o_div   (c_div[k+1])
        );
    end

    rths_post #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .STEPS         (STEPS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (c_vld[STEPS]),
        .i_ctl   (c_ctl[STEPS]),
        .i_w     (c_w[STEPS]),
        .i_ready (i_m_tready),
        .o_adv   (w_en),
        .o_vld   (o_m_tvalid),
        .o_hue   (w_hue),
        .o_sat   (w_sat),
        .o_lum   (w_lum)
    );

    assign o_m_tdata = {{M_PAD_W{1'b0}}, w_lum, w_sat, w_hue};

`ifndef NO_ASSERTIONS
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready while output register is empty");

    a_last_cell_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && c_vld[STEPS]) |=> o_m_tvalid)
        else $error("item from last cell did not reach the output register");

    a_row_frozen_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(c_vld[STEPS]))
        else $error("cell row moved while output was stalled");
`endif

endmodule
